/* rtl/jlvfp_pkg.sv */
package jlvfp_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    // intermediate products, squares and quotients are held in this many bits
    localparam int IW             = 64;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_JERK_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_ACCEL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_CAP   = 2'd2;

    localparam int JERK_LIMIT_RST  = 655360;
    localparam int TOTAL_ACCEL_RST = 196608;
    localparam int ACCEL_CAP_RST   = 131072;

endpackage

/* rtl/jerk_limited_velocity_forward_pass_unit.sv */
// Channel  Dir  Handshake              Payload
// s        in   s_tvalid / s_tready    s_tuser: first_point; s_tdata: curvature,
//                                      arc_length, velocity_ceiling
// m        out  m_tvalid / m_tready    m_tuser: accel_written; m_tdata: velocity,
//                                      acceleration
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// One point at a time. A first point or a zero-length step goes straight to the
// done state; a full step runs through the bit-serial multiplier (one operand bit
// a cycle), up to two square roots (one result bit a cycle) and the restoring
// divider (one quotient bit a cycle).
// A finished result waits in the output register while the next point is taken.
// rst_n clears control and trajectory state and loads the configuration defaults, asynchronously.
module jerk_limited_velocity_forward_pass_unit #(
    parameter int WORD_WIDTH = jlvfp_pkg::WORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // curvature, arc_length, velocity_ceiling (lowest bits first), zero padded
    input  logic [((3*WORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // first_point
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // velocity, acceleration (lowest bits first), zero padded
    output logic [((2*WORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    // accel_written
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [jlvfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [WORD_WIDTH-1:0]              cfg_data
);

    localparam int W      = WORD_WIDTH;
    localparam int IW     = jlvfp_pkg::IW;
    localparam int FB     = jlvfp_pkg::FRAC_BITS;
    localparam int SW     = IW + 2;
    localparam int CW     = $clog2(IW + 1);
    localparam int OUT_DW = ((2*WORD_WIDTH+7)/8)*8;

    localparam logic [IW-1:0] ONES   = {IW{1'b1}};
    localparam logic [W-1:0]  HALF_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  SMAX_W = {1'b0, {(W-1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE, S_V0SQ, S_LAT, S_AT2, S_LAT2, S_SQ1, S_JERK,
        S_AMUL, S_SQ2, S_VN2, S_DIV, S_DONE
    } state_t;

    state_t state_reg;

    logic [W-1:0]  jerk_reg, at_reg, cap_reg;
    logic [W-1:0]  last_vel_reg, last_arc_reg, last_k_reg, last_acc_reg;
    logic [W-1:0]  cur_k_reg, cur_arc_reg, ceil_reg, ds_reg;
    logic [IW-1:0] v0sq_reg, lat_reg, at2_reg, along_reg;
    logic          amin_neg_reg, dneg_reg;
    logic [W-1:0]  res_vel_reg, res_acc_reg;
    logic          res_wr_reg, keep_acc_reg;
    logic          out_valid_reg, out_wr_reg;
    logic [W-1:0]  out_vel_reg, out_acc_reg;
    logic [CW-1:0] cnt_reg;

    // shift-add multiplier, W-bit operand taken MSB first
    logic [W-1:0]  mul_a_reg;
    logic [IW-1:0] mul_b_reg, mul_p_reg;
    logic          mul_sat_reg;
    logic [IW:0]   mul_sum;
    logic          mul_ovf;
    logic [IW-1:0] mul_res;

    // bit-serial square root
    logic [IW-1:0] sq_x_reg, sq_r_reg, sq_b_reg;
    logic [IW-1:0] sq_t;
    logic          sq_ge;

    // restoring divider
    logic [IW-1:0] dv_q_reg, dv_r_reg, dv_d_reg;
    logic [IW:0]   dv_r2;
    logic          dv_ge;

    logic [W-1:0]  abs_k;
    logic [IW-1:0] lat_new, jt;
    logic [SW-1:0] jterm, along_s, cap_s, amin1, amin, amin_neg_v;
    logic [IW-1:0] amin_mag;
    logic [IW-1:0] tprod, rad;
    logic [IW:0]   rad_sum;
    logic [IW-1:0] vac, vnw64, mag_diff;
    logic          vn_neg;
    logic [W-1:0]  magc, magn, magp, acc_fin;
    logic          out_free;
    logic [W-1:0]  in_k, in_arc, in_ceil;

    assign in_k    = s_tdata[W-1:0];
    assign in_arc  = s_tdata[2*W-1:W];
    assign in_ceil = s_tdata[3*W-1:2*W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'({out_acc_reg, out_vel_reg});
    assign m_tuser  = out_wr_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign mul_sum = {mul_p_reg, 1'b0} + (mul_a_reg[W-1] ? {1'b0, mul_b_reg} : '0);
    assign mul_ovf = mul_p_reg[IW-1] | mul_sum[IW];
    assign mul_res = mul_sat_reg ? ONES : mul_p_reg;

    assign sq_t  = sq_r_reg + sq_b_reg;
    assign sq_ge = sq_x_reg >= sq_t;

    assign dv_r2 = {dv_r_reg, dv_q_reg[IW-1]};
    assign dv_ge = dv_r2 >= {1'b0, dv_d_reg};

    assign abs_k   = last_k_reg[W-1] ? (~last_k_reg + 1'b1) : last_k_reg;
    assign lat_new = mul_res >> FB;

    // least of friction-circle limit, cap and jerk-limited acceleration
    assign jt       = mul_res >> FB;
    assign jterm    = {{(SW-W){last_acc_reg[W-1]}}, last_acc_reg} + {2'b00, jt};
    assign along_s  = {2'b00, along_reg};
    assign cap_s    = SW'(cap_reg);
    assign amin1    = ($signed(cap_s) < $signed(along_s)) ? cap_s : along_s;
    assign amin     = ($signed(jterm) < $signed(amin1)) ? jterm : amin1;
    assign amin_neg_v = ~amin + 1'b1;
    assign amin_mag = amin[SW-1] ? amin_neg_v[IW-1:0] : amin[IW-1:0];

    // radicand v0^2 +/- 2*a*ds, saturated or clamped at zero
    assign tprod   = mul_res[IW-1] ? ONES : {mul_res[IW-2:0], 1'b0};
    assign rad_sum = {1'b0, v0sq_reg} + {1'b0, tprod};
    always_comb
    begin
        if (amin_neg_reg)
            rad = (v0sq_reg > tprod) ? (v0sq_reg - tprod) : '0;
        else
            rad = rad_sum[IW] ? ONES : rad_sum[IW-1:0];
    end

    assign vac   = sq_r_reg;
    assign vnw64 = ({{(IW-W){1'b0}}, ceil_reg} < vac) ? {{(IW-W){1'b0}}, ceil_reg} : vac;

    assign vn_neg   = mul_res < v0sq_reg;
    assign mag_diff = vn_neg ? (v0sq_reg - mul_res) : (mul_res - v0sq_reg);

    // clamp quotient to the total limit, then to the signed word range
    assign magc    = (dv_q_reg > {{(IW-W){1'b0}}, at_reg}) ? at_reg : dv_q_reg[W-1:0];
    assign magn    = (magc > HALF_W) ? HALF_W : magc;
    assign magp    = (magc > SMAX_W) ? SMAX_W : magc;
    assign acc_fin = dneg_reg ? (~magn + 1'b1) : magp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            jerk_reg      <= W'(jlvfp_pkg::JERK_LIMIT_RST);
            at_reg        <= W'(jlvfp_pkg::TOTAL_ACCEL_RST);
            cap_reg       <= W'(jlvfp_pkg::ACCEL_CAP_RST);
            last_vel_reg  <= '0;
            last_arc_reg  <= '0;
            last_k_reg    <= '0;
            last_acc_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_vel_reg   <= '0;
            out_acc_reg   <= '0;
            out_wr_reg    <= 1'b0;
            cur_k_reg     <= '0;
            cur_arc_reg   <= '0;
            ceil_reg      <= '0;
            ds_reg        <= '0;
            v0sq_reg      <= '0;
            lat_reg       <= '0;
            at2_reg       <= '0;
            along_reg     <= '0;
            amin_neg_reg  <= 1'b0;
            dneg_reg      <= 1'b0;
            res_vel_reg   <= '0;
            res_acc_reg   <= '0;
            res_wr_reg    <= 1'b0;
            keep_acc_reg  <= 1'b0;
            cnt_reg       <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_p_reg     <= '0;
            mul_sat_reg   <= 1'b0;
            sq_x_reg      <= '0;
            sq_r_reg      <= '0;
            sq_b_reg      <= '0;
            dv_q_reg      <= '0;
            dv_r_reg      <= '0;
            dv_d_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    jlvfp_pkg::REG_JERK_LIMIT:  jerk_reg <= cfg_data;
                    jlvfp_pkg::REG_TOTAL_ACCEL: at_reg   <= cfg_data;
                    jlvfp_pkg::REG_ACCEL_CAP:   cap_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // the done state reloads the output register itself
            if (out_valid_reg && m_tready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            // advance whichever serial unit the current step uses
            if (cnt_reg != '0)
            begin
                cnt_reg     <= cnt_reg - 1'b1;
                mul_p_reg   <= mul_sum[IW-1:0];
                mul_sat_reg <= mul_sat_reg | mul_ovf;
                mul_a_reg   <= mul_a_reg << 1;
                dv_q_reg    <= {dv_q_reg[IW-2:0], dv_ge};
                dv_r_reg    <= dv_ge ? (dv_r2[IW-1:0] - dv_d_reg) : dv_r2[IW-1:0];
            end
            if (sq_b_reg != '0)
            begin
                if (sq_ge)
                begin
                    sq_x_reg <= sq_x_reg - sq_t;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_b_reg <= sq_b_reg >> 2;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cur_k_reg   <= in_k;
                        cur_arc_reg <= in_arc;
                        ceil_reg    <= in_ceil;
                        ds_reg      <= in_arc - last_arc_reg;
                        if (s_tuser)
                        begin
                            res_vel_reg  <= '0;
                            res_acc_reg  <= '0;
                            res_wr_reg   <= 1'b0;
                            keep_acc_reg <= 1'b0;
                            state_reg    <= S_DONE;
                        end
                        else if (in_arc <= last_arc_reg)
                        begin
                            res_vel_reg  <= (in_ceil < last_vel_reg) ? in_ceil : last_vel_reg;
                            res_acc_reg  <= '0;
                            res_wr_reg   <= 1'b0;
                            keep_acc_reg <= 1'b1;
                            state_reg    <= S_DONE;
                        end
                        else
                        begin
                            keep_acc_reg <= 1'b0;
                            mul_a_reg    <= last_vel_reg;
                            mul_b_reg    <= IW'(last_vel_reg);
                            mul_p_reg    <= '0;
                            mul_sat_reg  <= 1'b0;
                            cnt_reg      <= CW'(W);
                            state_reg    <= S_V0SQ;
                        end
                    end
                end
                S_V0SQ:
                begin
                    if (cnt_reg == '0)
                    begin
                        v0sq_reg    <= mul_res;
                        mul_a_reg   <= abs_k;
                        mul_b_reg   <= mul_res >> FB;
                        mul_p_reg   <= '0;
                        mul_sat_reg <= 1'b0;
                        cnt_reg     <= CW'(W);
                        state_reg   <= S_LAT;
                    end
                end
                S_LAT:
                begin
                    if (cnt_reg == '0)
                    begin
                        lat_reg     <= lat_new;
                        mul_p_reg   <= '0;
                        mul_sat_reg <= 1'b0;
                        cnt_reg     <= CW'(W);
                        if (lat_new >= IW'(at_reg))
                        begin
                            along_reg <= '0;
                            mul_a_reg <= ds_reg;
                            mul_b_reg <= IW'(jerk_reg);
                            state_reg <= S_JERK;
                        end
                        else
                        begin
                            mul_a_reg <= at_reg;
                            mul_b_reg <= IW'(at_reg);
                            state_reg <= S_AT2;
                        end
                    end
                end
                S_AT2:
                begin
                    if (cnt_reg == '0)
                    begin
                        at2_reg     <= mul_res;
                        mul_a_reg   <= lat_reg[W-1:0];
                        mul_b_reg   <= lat_reg;
                        mul_p_reg   <= '0;
                        mul_sat_reg <= 1'b0;
                        cnt_reg     <= CW'(W);
                        state_reg   <= S_LAT2;
                    end
                end
                S_LAT2:
                begin
                    if (cnt_reg == '0)
                    begin
                        sq_x_reg  <= at2_reg - mul_res;
                        sq_r_reg  <= '0;
                        sq_b_reg  <= {2'b01, {(IW-2){1'b0}}};
                        state_reg <= S_SQ1;
                    end
                end
                S_SQ1:
                begin
                    if (sq_b_reg == '0)
                    begin
                        along_reg   <= sq_r_reg;
                        mul_a_reg   <= ds_reg;
                        mul_b_reg   <= IW'(jerk_reg);
                        mul_p_reg   <= '0;
                        mul_sat_reg <= 1'b0;
                        cnt_reg     <= CW'(W);
                        state_reg   <= S_JERK;
                    end
                end
                S_JERK:
                begin
                    if (cnt_reg == '0)
                    begin
                        amin_neg_reg <= amin[SW-1];
                        mul_a_reg    <= ds_reg;
                        mul_b_reg    <= amin_mag;
                        mul_p_reg    <= '0;
                        mul_sat_reg  <= 1'b0;
                        cnt_reg      <= CW'(W);
                        state_reg    <= S_AMUL;
                    end
                end
                S_AMUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        sq_x_reg  <= rad;
                        sq_r_reg  <= '0;
                        sq_b_reg  <= {2'b01, {(IW-2){1'b0}}};
                        state_reg <= S_SQ2;
                    end
                end
                S_SQ2:
                begin
                    if (sq_b_reg == '0)
                    begin
                        res_vel_reg <= vnw64[W-1:0];
                        if (last_vel_reg == '0 && vnw64 == '0)
                        begin
                            res_acc_reg <= '0;
                            res_wr_reg  <= 1'b1;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            mul_a_reg   <= vnw64[W-1:0];
                            mul_b_reg   <= vnw64;
                            mul_p_reg   <= '0;
                            mul_sat_reg <= 1'b0;
                            cnt_reg     <= CW'(W);
                            state_reg   <= S_VN2;
                        end
                    end
                end
                S_VN2:
                begin
                    if (cnt_reg == '0)
                    begin
                        dneg_reg  <= vn_neg;
                        dv_q_reg  <= mag_diff;
                        dv_r_reg  <= '0;
                        dv_d_reg  <= IW'({ds_reg, 1'b0});
                        cnt_reg   <= CW'(IW);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        res_acc_reg <= acc_fin;
                        res_wr_reg  <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_vel_reg   <= res_vel_reg;
                        out_acc_reg   <= res_acc_reg;
                        out_wr_reg    <= res_wr_reg;
                        last_vel_reg  <= res_vel_reg;
                        last_arc_reg  <= cur_arc_reg;
                        last_k_reg    <= cur_k_reg;
                        if (!keep_acc_reg)
                            last_acc_reg <= res_acc_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
